// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files of the option parser.
// Each macro expects i_clk to be visible where it is used; ASSERT_NOW and ASSERT_NEXT also need i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/otsp_pkg.sv
// Types and constants of the option TLV stream parser.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package otsp_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] option_type;
        logic [63:0] value_length;
        logic [7:0]  value_byte;
        logic        empty_marker;
        logic        option_end;
        logic        run_last;
    } t_out;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;
    localparam int CONT_BIT    = 7;
    localparam int DIGIT_W     = 7;
    localparam logic [FIFO_CNT_W-1:0] FIFO_STALL_AT = 3'd3;

endpackage

`default_nettype wire

// File: rtl/option_tlv_stream_parser_top.sv
// Option TLV stream parser: base-128 varint length/type decode and value pass-through.
// Depends on otsp_pkg.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    i_in_data   (otsp_pkg::t_in)
//   out       output     o_out_valid / i_out_stall  o_out_data  (otsp_pkg::t_out)
//   cfg       input      i_cfg_we                   i_cfg_wdata (saturate_enable)
//
// One byte is taken per cycle while o_in_stall is low; its results are written
// to a four-entry result queue in the same edge, so the first result can be visible
// in the cycle after the transfer; a second (error) result goes in behind it.
// o_in_stall is registered and rises when the queue holds three or more results.
// Synchronous reset clears the parse state and the queue; saturate_enable resets to 1.
`default_nettype none

module option_tlv_stream_parser_top #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  otsp_pkg::t_in   i_in_data,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output otsp_pkg::t_out  o_out_data,
    input  logic            i_out_stall,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata
);
    import otsp_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam logic [W-1:0] VMASK = '1;

    typedef enum logic [2:0] {
        PH_LEN   = 3'b001,
        PH_TYPE  = 3'b010,
        PH_VALUE = 3'b100
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [W-1:0]           r_acc, n_acc;
    logic [W-1:0]           r_rem, n_rem;
    logic                   r_ovf, n_ovf;
    logic                   r_sat;
    logic                   r_in_stall, n_in_stall;
    logic [FIFO_CNT_W-1:0]  r_count, n_count;
    logic [FIFO_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    t_out                   r_fifo [FIFO_DEPTH];

    logic          accept;
    logic          more;
    logic          last;
    logic [W-1:0]  absorbed;
    logic          ovf;
    logic [W-1:0]  varint;
    logic [W-1:0]  rem_dec;
    logic          done;
    logic          restart;
    logic          res_v;
    logic          err_v;
    logic          pop;
    t_out          res;
    t_out          err_res;

    assign accept   = i_in_valid && !r_in_stall;
    assign more     = i_in_data.in_byte[CONT_BIT];
    assign last     = i_in_data.buffer_end;
    assign absorbed = {r_acc[W-DIGIT_W-1:0], i_in_data.in_byte[DIGIT_W-1:0]};
    assign ovf      = r_ovf | (|r_acc[W-1:W-DIGIT_W]);
    assign varint   = (ovf && r_sat) ? VMASK : absorbed;
    assign rem_dec  = r_rem - W'(1);
    assign done     = (rem_dec == '0);

    always_comb begin
        err_res          = '0;
        err_res.kind     = KIND_ERROR;
        err_res.run_last = 1'b1;
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_ovf   = r_ovf;
        res     = '0;
        res_v   = 1'b0;
        err_v   = 1'b0;
        restart = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_TYPE: begin
                    n_rem = rem_dec;
                    n_acc = absorbed;
                    n_ovf = ovf;
                    if (more) begin
                        if (done || last) begin
                            err_v   = 1'b1;
                            restart = 1'b1;
                        end
                    end else begin
                        res_v              = 1'b1;
                        res.kind           = KIND_HEADER;
                        res.option_type    = 64'(varint);
                        res.value_length   = 64'(rem_dec);
                        res.option_end     = done;
                        n_acc              = '0;
                        n_ovf              = 1'b0;
                        if (done) begin
                            restart = 1'b1;
                        end else if (last) begin
                            err_v   = 1'b1;
                            restart = 1'b1;
                        end else begin
                            n_phase = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    n_rem          = rem_dec;
                    res_v          = 1'b1;
                    res.kind       = KIND_VALUE;
                    res.value_byte = i_in_data.in_byte;
                    res.option_end = done;
                    if (done) begin
                        restart = 1'b1;
                    end else if (last) begin
                        err_v   = 1'b1;
                        restart = 1'b1;
                    end
                end
                default: begin
                    n_acc = absorbed;
                    n_ovf = ovf;
                    if (more) begin
                        n_phase = PH_LEN;
                        if (last) begin
                            err_v   = 1'b1;
                            restart = 1'b1;
                        end
                    end else if (varint == '0) begin
                        res_v            = 1'b1;
                        res.kind         = KIND_HEADER;
                        res.empty_marker = 1'b1;
                        res.option_end   = 1'b1;
                        restart          = 1'b1;
                    end else if (last) begin
                        err_v   = 1'b1;
                        restart = 1'b1;
                    end else begin
                        n_rem   = varint;
                        n_acc   = '0;
                        n_ovf   = 1'b0;
                        n_phase = PH_TYPE;
                    end
                end
            endcase
            res.run_last = !err_v;
        end
        if (restart) begin
            n_phase = PH_LEN;
            n_acc   = '0;
            n_rem   = '0;
            n_ovf   = 1'b0;
        end
    end

    assign pop        = (r_count != '0) && !i_out_stall;
    assign n_count    = r_count + FIFO_CNT_W'(res_v) + FIFO_CNT_W'(err_v)
                        - FIFO_CNT_W'(pop);
    assign n_wr_ptr   = r_wr_ptr + FIFO_PTR_W'(res_v) + FIFO_PTR_W'(err_v);
    assign n_rd_ptr   = r_rd_ptr + FIFO_PTR_W'(pop);
    assign n_in_stall = (n_count >= FIFO_STALL_AT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEN;
            r_acc      <= '0;
            r_rem      <= '0;
            r_ovf      <= 1'b0;
            r_sat      <= 1'b1;
            r_in_stall <= 1'b0;
            r_count    <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
        end else begin
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_rem      <= n_rem;
            r_ovf      <= n_ovf;
            r_in_stall <= n_in_stall;
            r_count    <= n_count;
            r_wr_ptr   <= n_wr_ptr;
            r_rd_ptr   <= n_rd_ptr;
            if (i_cfg_we) begin
                r_sat <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_v) begin
            r_fifo[r_wr_ptr] <= res;
        end
        if (err_v) begin
            r_fifo[r_wr_ptr + FIFO_PTR_W'(res_v)] <= err_res;
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];

endmodule

`default_nettype wire

// File: rtl/otsp_checker.sv
// Port-level checks for the option TLV stream parser, bound to its top level.
// Depends on otsp_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module otsp_checker (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  otsp_pkg::t_in   i_in_data,
    input  wire             o_in_stall,
    input  wire             o_out_valid,
    input  otsp_pkg::t_out  o_out_data,
    input  wire             i_out_stall
);
    import otsp_pkg::*;

    logic err_shape_ok;
    logic empty_shape_ok;

    assign err_shape_ok   = o_out_data.run_last && !o_out_data.option_end
                            && (o_out_data.option_type == 64'd0)
                            && (o_out_data.value_length == 64'd0);
    assign empty_shape_ok = (o_out_data.kind == KIND_HEADER) && o_out_data.option_end
                            && o_out_data.run_last && (o_out_data.value_length == 64'd0);

    `ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(i_in_data))
    `ASSERT_NOW(a_err_shape, o_out_valid && o_out_data.kind == KIND_ERROR, err_shape_ok)
    `ASSERT_NOW(a_empty_hdr, o_out_valid && o_out_data.empty_marker, empty_shape_ok)
    `ASSERT_NEXT_ALWAYS(a_rst_clear, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind option_tlv_stream_parser_top otsp_checker u_otsp_checker (.*);

`default_nettype wire
